@@ rtl/pffa_pkg.sv @@
// Shared types, codes and constants for the page first-fit allocator.
`default_nettype none

package pffa_pkg;

   localparam int PAGE_BYTES_DEF = 1024;
   localparam int PAGE_COUNT_DEF = 1024;

   localparam int SIZE_W  = 21;
   localparam int ADDR_W  = 20;
   localparam int CODE_W  = 2;
   localparam int COUNT_W = 10;
   localparam int HEADS_W = 11;

   typedef enum logic [CODE_W-1:0] {
      RC_OK,
      RC_OOM,
      RC_LOW_ADDR,
      RC_BAD_FREE
   } code_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_START,
      OP_DIV,
      OP_SPLIT,
      OP_TAKE_TAIL,
      OP_TAKE,
      OP_FREE_MARK,
      OP_FWD,
      OP_BWD,
      OP_CNT_INIT,
      OP_CNT_ADD,
      OP_PUBLISH
   } op_type;

   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_ZERO,
      CUR_NEXT_RD,
      CUR_PAGE,
      CUR_NEXT_H,
      CUR_HPREV
   } cur_sel_type;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV,
      S_DECIDE,
      S_A_RD,
      S_A_EX,
      S_A_TAKE,
      S_F_RD,
      S_F_CHK,
      S_F_NX,
      S_F_RD2,
      S_F_NE,
      S_B_ST,
      S_B_RD,
      S_B_EX,
      S_CNT0,
      S_C_RD,
      S_C_EX,
      S_DONE
   } state_type;

   typedef struct packed {
      op_type      op;
      cur_sel_type cur_sel;
      logic        rd_en;
      logic        code_we;
      code_type    code;
      logic        addr_we;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic is_free;
      logic addr_low;
      logic misaligned;
      logic page_oob;
      logic at_tail;
      logic fits_tail;
      logic fits_mid;
      logic rd_live;
      logic rd_inuse;
      logic h_is_tail;
      logic h_zero;
      logic next_oob;
      logic rsp_busy;
   } dp_status_type;

endpackage

`default_nettype wire

@@ rtl/pffa_ctrl.sv @@
// Sequencer for the allocator: clears the tables after reset, then steps the datapath through each request.
`default_nettype none

module pffa_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire pffa_pkg::dp_status_type status,
   output pffa_pkg::ctrl_cmd_type      cmd,
   output logic                        req_stall
);

   pffa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pffa_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd.op      = pffa_pkg::OP_NONE;
      cmd.cur_sel = pffa_pkg::CUR_HOLD;
      cmd.rd_en   = 1'b0;
      cmd.code_we = 1'b0;
      cmd.code    = pffa_pkg::RC_OK;
      cmd.addr_we = 1'b0;
      req_stall   = (state_ff != pffa_pkg::S_IDLE);

      unique case (state_ff)
         pffa_pkg::S_CLEAR: begin
            cmd.op = pffa_pkg::OP_CLEAR;
            if (status.clr_last) begin
               state_in = pffa_pkg::S_IDLE;
            end
         end
         pffa_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.op   = pffa_pkg::OP_START;
               state_in = pffa_pkg::S_DIV;
            end
         end
         pffa_pkg::S_DIV: begin
            cmd.op   = pffa_pkg::OP_DIV;
            state_in = pffa_pkg::S_DECIDE;
         end
         pffa_pkg::S_DECIDE: begin
            priority if (!status.is_free) begin
               cmd.cur_sel = pffa_pkg::CUR_ZERO;
               state_in    = pffa_pkg::S_A_RD;
            end else if (status.addr_low) begin
               cmd.code_we = 1'b1;
               cmd.code    = pffa_pkg::RC_LOW_ADDR;
               state_in    = pffa_pkg::S_CNT0;
            end else if (status.misaligned || status.page_oob) begin
               cmd.code_we = 1'b1;
               cmd.code    = pffa_pkg::RC_BAD_FREE;
               state_in    = pffa_pkg::S_CNT0;
            end else begin
               cmd.cur_sel = pffa_pkg::CUR_PAGE;
               state_in    = pffa_pkg::S_F_RD;
            end
         end
         pffa_pkg::S_A_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = pffa_pkg::S_A_EX;
         end
         pffa_pkg::S_A_EX: begin
            priority if (status.at_tail) begin
               if (status.fits_tail) begin
                  cmd.op   = pffa_pkg::OP_SPLIT;
                  state_in = pffa_pkg::S_A_TAKE;
               end else begin
                  cmd.code_we = 1'b1;
                  cmd.code    = pffa_pkg::RC_OOM;
                  state_in    = pffa_pkg::S_CNT0;
               end
            end else if (status.fits_mid) begin
               cmd.op      = pffa_pkg::OP_TAKE;
               cmd.addr_we = 1'b1;
               state_in    = pffa_pkg::S_CNT0;
            end else begin
               cmd.cur_sel = pffa_pkg::CUR_NEXT_RD;
               state_in    = pffa_pkg::S_A_RD;
            end
         end
         pffa_pkg::S_A_TAKE: begin
            cmd.op      = pffa_pkg::OP_TAKE_TAIL;
            cmd.addr_we = 1'b1;
            state_in    = pffa_pkg::S_CNT0;
         end
         pffa_pkg::S_F_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = pffa_pkg::S_F_CHK;
         end
         pffa_pkg::S_F_CHK: begin
            if (status.rd_live) begin
               cmd.op   = pffa_pkg::OP_FREE_MARK;
               state_in = pffa_pkg::S_F_NX;
            end else begin
               cmd.code_we = 1'b1;
               cmd.code    = pffa_pkg::RC_BAD_FREE;
               state_in    = pffa_pkg::S_CNT0;
            end
         end
         pffa_pkg::S_F_NX: begin
            if (status.h_is_tail || status.next_oob) begin
               state_in = pffa_pkg::S_B_ST;
            end else begin
               cmd.cur_sel = pffa_pkg::CUR_NEXT_H;
               state_in    = pffa_pkg::S_F_RD2;
            end
         end
         pffa_pkg::S_F_RD2: begin
            cmd.rd_en = 1'b1;
            state_in  = pffa_pkg::S_F_NE;
         end
         pffa_pkg::S_F_NE: begin
            if (status.rd_inuse) begin
               state_in = pffa_pkg::S_B_ST;
            end else begin
               cmd.op   = pffa_pkg::OP_FWD;
               state_in = pffa_pkg::S_F_NX;
            end
         end
         pffa_pkg::S_B_ST: begin
            if (status.h_zero) begin
               state_in = pffa_pkg::S_CNT0;
            end else begin
               cmd.cur_sel = pffa_pkg::CUR_HPREV;
               state_in    = pffa_pkg::S_B_RD;
            end
         end
         pffa_pkg::S_B_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = pffa_pkg::S_B_EX;
         end
         pffa_pkg::S_B_EX: begin
            if (status.rd_inuse) begin
               state_in = pffa_pkg::S_CNT0;
            end else begin
               cmd.op   = pffa_pkg::OP_BWD;
               state_in = pffa_pkg::S_B_ST;
            end
         end
         pffa_pkg::S_CNT0: begin
            cmd.op      = pffa_pkg::OP_CNT_INIT;
            cmd.cur_sel = pffa_pkg::CUR_ZERO;
            state_in    = pffa_pkg::S_C_RD;
         end
         pffa_pkg::S_C_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = pffa_pkg::S_C_EX;
         end
         pffa_pkg::S_C_EX: begin
            cmd.op = pffa_pkg::OP_CNT_ADD;
            if (status.at_tail) begin
               state_in = pffa_pkg::S_DONE;
            end else begin
               cmd.cur_sel = pffa_pkg::CUR_NEXT_RD;
               state_in    = pffa_pkg::S_C_RD;
            end
         end
         pffa_pkg::S_DONE: begin
            // hold until the output register is free
            if (!status.rsp_busy) begin
               cmd.op   = pffa_pkg::OP_PUBLISH;
               state_in = pffa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pffa_pkg::S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/pffa_dpath.sv @@
// Datapath of the allocator: block tables, page split, walk pointers, counts.
`default_nettype none

module pffa_dpath #(
   parameter int PAGE_BYTES = pffa_pkg::PAGE_BYTES_DEF,
   parameter int PAGE_COUNT = pffa_pkg::PAGE_COUNT_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire pffa_pkg::ctrl_cmd_type            cmd,
   output pffa_pkg::dp_status_type                status,
   input  wire logic                              req_cmd,
   input  wire logic [pffa_pkg::SIZE_W-1:0]       req_size_bytes,
   input  wire logic [pffa_pkg::ADDR_W-1:0]       req_block_address,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [pffa_pkg::ADDR_W-1:0]            rsp_data_address,
   output logic [pffa_pkg::CODE_W-1:0]            rsp_result_code,
   output logic [pffa_pkg::COUNT_W-1:0]           rsp_pages_in_use,
   output logic [pffa_pkg::COUNT_W-1:0]           rsp_pages_fragmented,
   output logic [pffa_pkg::HEADS_W-1:0]           rsp_header_count,
   output logic [pffa_pkg::COUNT_W-1:0]           rsp_tail_free_pages
);

   localparam int PW  = $clog2(PAGE_COUNT);
   localparam int DW  = pffa_pkg::SIZE_W;
   localparam int AW  = pffa_pkg::ADDR_W;
   // PAGE_BYTES must be a power of two, the block does not check it: page number and offset are a shift and a mask
   localparam int RW  = $clog2(PAGE_BYTES);
   localparam int NW  = DW + 1;
   localparam int PRW = PW + 1 + RW + AW;

   // block tables: {head, in use}, data pages, previous header
   logic [1:0]    meta_mem [PAGE_COUNT];
   logic [PW-1:0] bp_mem   [PAGE_COUNT];
   logic [PW-1:0] prev_mem [PAGE_COUNT];

   logic [1:0]    rd_meta_ff;
   logic [PW-1:0] rd_bp_ff, rd_prev_ff;

   logic          meta_we, bp_we, prev_we;
   logic [PW-1:0] meta_wa, bp_wa, prev_wa;
   logic [1:0]    meta_wd;
   logic [PW-1:0] bp_wd, prev_wd;

   logic [PW-1:0] clr_ff, clr_in;
   logic          cmd_ff, cmd_in;
   logic [DW-1:0] dvd_ff, dvd_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [PW:0]   cur_ff, cur_in;
   logic [PW-1:0] h_ff, h_in, hbp_ff, hbp_in, hprev_ff, hprev_in;
   logic [PW-1:0] tail_ff, tail_in;
   logic [PW-1:0] use_ff, use_in, frag_ff, frag_in, tfree_ff, tfree_in;
   logic [PW:0]   heads_ff, heads_in;
   logic [AW-1:0] addr_ff, addr_in;
   pffa_pkg::code_type code_ff, code_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [AW-1:0]               rsp_addr_ff;
   pffa_pkg::code_type          rsp_code_ff;
   logic [PW-1:0]               rsp_use_ff, rsp_frag_ff, rsp_tfree_ff;
   logic [PW:0]                 rsp_heads_ff;

   logic [NW-1:0] needed, rd_bp_x;
   logic [DW-1:0] page_m1;
   logic [PW:0]   next_rd, next_h, n_split, nx_fwd, nx_bwd;
   logic [PW:0]   hbp_fwd, qbp;
   logic [PRW-1:0] prod;

   always_comb begin
      needed   = NW'(dvd_ff) + NW'(rem_ff != '0);
      rd_bp_x  = NW'(rd_bp_ff);
      page_m1  = dvd_ff - DW'(1);
      next_rd  = cur_ff + (PW+1)'(rd_bp_ff) + (PW+1)'(1);
      next_h   = (PW+1)'(h_ff) + (PW+1)'(hbp_ff) + (PW+1)'(1);
      n_split  = cur_ff + needed[PW:0] + (PW+1)'(1);
      hbp_fwd  = (PW+1)'(hbp_ff) + (PW+1)'(rd_bp_ff) + (PW+1)'(1);
      nx_fwd   = (PW+1)'(h_ff) + hbp_fwd + (PW+1)'(1);
      qbp      = (PW+1)'(rd_bp_ff) + (PW+1)'(hbp_ff) + (PW+1)'(1);
      nx_bwd   = cur_ff + qbp + (PW+1)'(1);
      prod     = PRW'(cur_ff + (PW+1)'(1)) * PRW'(PAGE_BYTES);
   end

   always_comb begin
      status.clr_last   = (clr_ff == PW'(PAGE_COUNT - 1));
      status.is_free    = cmd_ff;
      status.addr_low   = (dvd_ff == '0);
      status.misaligned = (rem_ff != '0);
      status.page_oob   = (dvd_ff > DW'(PAGE_COUNT));
      status.at_tail    = (cur_ff == (PW+1)'(tail_ff));
      status.fits_tail  = (rd_bp_x >= needed + NW'(1));
      status.fits_mid   = !rd_meta_ff[0] && (rd_bp_x >= needed);
      status.rd_live    = rd_meta_ff[1] && rd_meta_ff[0];
      status.rd_inuse   = rd_meta_ff[0];
      status.h_is_tail  = (h_ff == tail_ff);
      status.h_zero     = (h_ff == '0);
      status.next_oob   = (next_h >= (PW+1)'(PAGE_COUNT));
      status.rsp_busy   = rsp_valid_ff && rsp_stall;
   end

   always_comb begin
      clr_in       = clr_ff;
      cmd_in       = cmd_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      cur_in       = cur_ff;
      h_in         = h_ff;
      hbp_in       = hbp_ff;
      hprev_in     = hprev_ff;
      tail_in      = tail_ff;
      use_in       = use_ff;
      frag_in      = frag_ff;
      tfree_in     = tfree_ff;
      heads_in     = heads_ff;
      addr_in      = addr_ff;
      code_in      = code_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      meta_we = 1'b0;  meta_wa = cur_ff[PW-1:0]; meta_wd = 2'b00;
      bp_we   = 1'b0;  bp_wa   = cur_ff[PW-1:0]; bp_wd   = '0;
      prev_we = 1'b0;  prev_wa = cur_ff[PW-1:0]; prev_wd = '0;

      unique case (cmd.op)
         pffa_pkg::OP_CLEAR: begin
            meta_we = 1'b1; meta_wa = clr_ff;
            meta_wd = (clr_ff == '0) ? 2'b10 : 2'b00;
            bp_we   = 1'b1; bp_wa = clr_ff;
            bp_wd   = (clr_ff == '0) ? PW'(PAGE_COUNT - 1) : '0;
            prev_we = 1'b1; prev_wa = clr_ff;
            clr_in  = clr_ff + PW'(1);
         end
         pffa_pkg::OP_START: begin
            cmd_in  = req_cmd;
            dvd_in  = req_cmd ? DW'(req_block_address) : req_size_bytes;
            rem_in  = '0;
            addr_in = '0;
            code_in = pffa_pkg::RC_OK;
         end
         pffa_pkg::OP_DIV: begin
            // split into whole pages and the offset within the page
            dvd_in = dvd_ff >> RW;
            rem_in = dvd_ff[RW-1:0];
         end
         pffa_pkg::OP_SPLIT: begin
            // new tail header right after the taken pages
            meta_we = 1'b1; meta_wa = n_split[PW-1:0]; meta_wd = 2'b10;
            bp_we   = 1'b1; bp_wa   = n_split[PW-1:0];
            bp_wd   = rd_bp_ff - needed[PW-1:0] - PW'(1);
            prev_we = 1'b1; prev_wa = n_split[PW-1:0]; prev_wd = cur_ff[PW-1:0];
            tail_in = n_split[PW-1:0];
         end
         pffa_pkg::OP_TAKE_TAIL: begin
            meta_we = 1'b1; meta_wd = 2'b11;
            bp_we   = 1'b1; bp_wd   = needed[PW-1:0];
         end
         pffa_pkg::OP_TAKE: begin
            meta_we = 1'b1; meta_wd = 2'b11;
         end
         pffa_pkg::OP_FREE_MARK: begin
            meta_we  = 1'b1; meta_wd = 2'b10;
            h_in     = cur_ff[PW-1:0];
            hbp_in   = rd_bp_ff;
            hprev_in = rd_prev_ff;
         end
         pffa_pkg::OP_FWD: begin
            // absorb the following free block into h
            meta_we = 1'b1;
            bp_we   = 1'b1; bp_wa = h_ff; bp_wd = hbp_fwd[PW-1:0];
            hbp_in  = hbp_fwd[PW-1:0];
            if (status.at_tail) begin
               tail_in = h_ff;
            end else if (nx_fwd < (PW+1)'(PAGE_COUNT)) begin
               prev_we = 1'b1; prev_wa = nx_fwd[PW-1:0]; prev_wd = h_ff;
            end
         end
         pffa_pkg::OP_BWD: begin
            // fold h into the free block before it
            bp_we   = 1'b1; bp_wd = qbp[PW-1:0];
            meta_we = 1'b1; meta_wa = h_ff;
            if (status.h_is_tail) begin
               tail_in = cur_ff[PW-1:0];
            end else if (nx_bwd < (PW+1)'(PAGE_COUNT)) begin
               prev_we = 1'b1; prev_wa = nx_bwd[PW-1:0]; prev_wd = cur_ff[PW-1:0];
            end
            h_in     = cur_ff[PW-1:0];
            hbp_in   = qbp[PW-1:0];
            hprev_in = rd_prev_ff;
         end
         pffa_pkg::OP_CNT_INIT: begin
            use_in   = '0;
            frag_in  = '0;
            heads_in = '0;
         end
         pffa_pkg::OP_CNT_ADD: begin
            heads_in = heads_ff + (PW+1)'(1);
            if (rd_meta_ff[0]) begin
               use_in = use_ff + rd_bp_ff;
            end else if (!status.at_tail) begin
               frag_in = frag_ff + rd_bp_ff;
            end
            if (status.at_tail) begin
               tfree_in = rd_bp_ff;
            end
         end
         pffa_pkg::OP_PUBLISH: begin
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase

      unique case (cmd.cur_sel)
         pffa_pkg::CUR_HOLD:    cur_in = cur_ff;
         pffa_pkg::CUR_ZERO:    cur_in = '0;
         pffa_pkg::CUR_NEXT_RD: cur_in = next_rd;
         pffa_pkg::CUR_PAGE:    cur_in = page_m1[PW:0];
         pffa_pkg::CUR_NEXT_H:  cur_in = next_h;
         pffa_pkg::CUR_HPREV:   cur_in = (PW+1)'(hprev_ff);
         default:               cur_in = cur_ff;
      endcase

      if (cmd.code_we) begin
         code_in = cmd.code;
      end
      if (cmd.addr_we) begin
         addr_in = prod[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      cur_ff   <= cur_in;
      h_ff     <= h_in;
      hbp_ff   <= hbp_in;
      hprev_ff <= hprev_in;
      use_ff   <= use_in;
      frag_ff  <= frag_in;
      tfree_ff <= tfree_in;
      heads_ff <= heads_in;
      addr_ff  <= addr_in;
      code_ff  <= code_in;
      if (cmd.op == pffa_pkg::OP_PUBLISH) begin
         rsp_addr_ff  <= addr_ff;
         rsp_code_ff  <= code_ff;
         rsp_use_ff   <= use_ff;
         rsp_frag_ff  <= frag_ff;
         rsp_heads_ff <= heads_ff;
         rsp_tfree_ff <= tfree_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_wa] <= meta_wd;
      end
      if (bp_we) begin
         bp_mem[bp_wa] <= bp_wd;
      end
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
      if (cmd.rd_en) begin
         rd_meta_ff <= meta_mem[cur_ff[PW-1:0]];
         rd_bp_ff   <= bp_mem[cur_ff[PW-1:0]];
         rd_prev_ff <= prev_mem[cur_ff[PW-1:0]];
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_data_address     = rsp_addr_ff;
   assign rsp_result_code      = rsp_code_ff;
   assign rsp_pages_in_use     = pffa_pkg::COUNT_W'(rsp_use_ff);
   assign rsp_pages_fragmented = pffa_pkg::COUNT_W'(rsp_frag_ff);
   assign rsp_header_count     = pffa_pkg::HEADS_W'(rsp_heads_ff);
   assign rsp_tail_free_pages  = pffa_pkg::COUNT_W'(rsp_tfree_ff);

   a_tail_in_range: assert property (@(posedge clock) disable iff (reset)
      tail_ff <= PW'(PAGE_COUNT - 1))
      else $error("tail header outside the region");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> cur_ff < (PW+1)'(PAGE_COUNT))
      else $error("table read past the region");

   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == pffa_pkg::OP_PUBLISH |-> !(rsp_valid_ff && rsp_stall))
      else $error("response overwritten while stalled");

   a_walk_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.op == pffa_pkg::OP_CNT_ADD |-> heads_ff < (PW+1)'(PAGE_COUNT))
      else $error("block walk ran past the page count");

endmodule

`default_nettype wire

@@ rtl/page_first_fit_allocator.sv @@
// Top level of the page first-fit allocator with coalescing.
//
//   channel | ports | direction | accepted when
//   request  | req_valid, req_stall, req_cmd, req_size_bytes, req_block_address | in
//            | req_valid && !req_stall
//   response | rsp_valid, rsp_stall, rsp_data_address .. rsp_tail_free_pages | out
//            | rsp_valid && !rsp_stall
//
// One request at a time. After it is accepted in the idle state, a request has its size
// or address split into pages and offset (PAGE_BYTES must be a power of two; the block
// does not check it) and is then decided. An allocate then reads and examines each block
// of the first-fit walk, with an extra step when carving from the tail; a free looks up
// its header, then examines neighbors forward and then backward, a walk stopping at an
// in-use block, at the tail or at page zero. Every request ends with a count walk over all
// blocks and a publish; the walks over the header tables (one read port) set the rate.
// After reset a clearing pass over all PAGE_COUNT headers runs with req_stall high.
// A finished response waits in the output register; a stalled response holds
// the next one back in its final cycle.
`default_nettype none

module page_first_fit_allocator #(
   parameter int PAGE_BYTES = pffa_pkg::PAGE_BYTES_DEF,
   parameter int PAGE_COUNT = pffa_pkg::PAGE_COUNT_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_cmd,
   input  wire logic [pffa_pkg::SIZE_W-1:0]   req_size_bytes,
   input  wire logic [pffa_pkg::ADDR_W-1:0]   req_block_address,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [pffa_pkg::ADDR_W-1:0]        rsp_data_address,
   output logic [pffa_pkg::CODE_W-1:0]        rsp_result_code,
   output logic [pffa_pkg::COUNT_W-1:0]       rsp_pages_in_use,
   output logic [pffa_pkg::COUNT_W-1:0]       rsp_pages_fragmented,
   output logic [pffa_pkg::HEADS_W-1:0]       rsp_header_count,
   output logic [pffa_pkg::COUNT_W-1:0]       rsp_tail_free_pages
);

   pffa_pkg::ctrl_cmd_type  cmd;
   pffa_pkg::dp_status_type status;

   pffa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   pffa_dpath #(
      .PAGE_BYTES (PAGE_BYTES),
      .PAGE_COUNT (PAGE_COUNT)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_cmd              (req_cmd),
      .req_size_bytes       (req_size_bytes),
      .req_block_address    (req_block_address),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_data_address     (rsp_data_address),
      .rsp_result_code      (rsp_result_code),
      .rsp_pages_in_use     (rsp_pages_in_use),
      .rsp_pages_fragmented (rsp_pages_fragmented),
      .rsp_header_count     (rsp_header_count),
      .rsp_tail_free_pages  (rsp_tail_free_pages)
   );

endmodule

`default_nettype wire
